>>> rtl/core/nxpc_pkg.sv
// Package for the RV32IC next-pc predictor: transaction payload types,
// command codes, opcode and compressed-instruction match constants.
// No dependencies.
`default_nettype none

package nxpc_pkg;

    localparam int unsigned XLEN    = 32;
    localparam int unsigned NUM_REG = 32;
    localparam int unsigned REG_AW  = $clog2(NUM_REG);

    // Command codes
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_PREDICT = 1'b1;

    // 32-bit major opcodes
    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_STORE = 7'h23;
    localparam logic [6:0] OPC_CTRL  = 7'h63;  // bits common to BRANCH/JAL/JALR

    // opcode[4:2] inside the control-transfer group
    localparam logic [2:0] CTL_BRANCH = 3'd0;
    localparam logic [2:0] CTL_JALR   = 3'd1;
    localparam logic [2:0] CTL_JAL    = 3'd3;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // compressed quadrants and funct3
    localparam logic [1:0] CQ0     = 2'b00;
    localparam logic [1:0] CQ1     = 2'b01;
    localparam logic [1:0] CQ2     = 2'b10;
    localparam logic [1:0] CQ_NONE = 2'b11;
    localparam logic [2:0] CF3_JAL  = 3'd1;
    localparam logic [2:0] CF3_J    = 3'd5;
    localparam logic [2:0] CF3_BEQZ = 3'd6;
    localparam logic [2:0] CF3_BNEZ = 3'd7;
    localparam logic [2:0] CF3_LW   = 3'd2;  // C.LW / C.LWSP
    localparam logic [2:0] CF3_SW   = 3'd6;  // C.SW / C.SWSP

    // C.JR / C.JALR match
    localparam logic [15:0] CJR_MASK  = 16'hE07F;
    localparam logic [15:0] CJR_MATCH = 16'h8002;

    typedef struct packed {
        logic                cmd;
        logic [REG_AW-1:0]   reg_index;
        logic [XLEN-1:0]     reg_value;
        logic [XLEN-1:0]     pc;
        logic [XLEN-1:0]     instr_word;
    } t_pred_in;

    typedef struct packed {
        logic [XLEN-1:0]     next_pc;
        logic                is_load_store;
        logic                is_compressed;
    } t_pred_out;

endpackage

`default_nettype wire

>>> rtl/core/riscv_next_pc_predictor_unit.sv
// RV32IC next-pc predictor: register copy, operand read and next-pc compute.
// Depends on nxpc_pkg.
//
// A predict transaction reads its registers into the operand stage at the edge
// that accepts it, then its computed next pc moves into the output register;
// both stages hold while the output is stalled. Throughput: one transaction
// per cycle while not stalled; a write takes effect at its acceptance.
// Reset clears the 32 per-register valid bits at once, so every register reads
// zero until written; no clearing pass is needed.
`default_nettype none

module riscv_next_pc_predictor_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire nxpc_pkg::t_pred_in i_in,
    output logic                  o_valid,
    input  wire                   i_ready,
    output nxpc_pkg::t_pred_out   o_out
);
    import nxpc_pkg::*;

    logic [XLEN-1:0]   r_mem [NUM_REG];
    logic [NUM_REG-1:0] r_reg_vld;

    logic              r_s1_vld;
    t_pred_in          r_s1;
    logic [XLEN-1:0]   r_opa;
    logic [XLEN-1:0]   r_opb;

    logic              r_out_vld;
    t_pred_out         r_out;

    logic              out_adv;
    logic              in_acc;
    logic              wr_en;
    logic              rd_en;
    logic [REG_AW-1:0] rd_addr_a;
    logic [REG_AW-1:0] rd_addr_b;
    logic [31:0]       iw;

    assign out_adv = !r_out_vld || i_ready;
    assign o_ready = !r_s1_vld || out_adv;
    assign in_acc  = i_valid && o_ready;
    assign wr_en   = in_acc && (i_in.cmd == CMD_WRITE) && (i_in.reg_index != '0);
    assign rd_en   = in_acc && (i_in.cmd == CMD_PREDICT);
    assign iw      = i_in.instr_word;

    // port A: rs1, or rs1' for CB branches, or rs1 of C.JR/C.JALR
    always_comb begin
        if (iw[1:0] == CQ_NONE) begin
            rd_addr_a = iw[19:15];
        end else if (iw[1:0] == CQ1) begin
            rd_addr_a = {2'b01, iw[9:7]};
        end else begin
            rd_addr_a = iw[11:7];
        end
        rd_addr_b = iw[24:20];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_in.reg_index] <= i_in.reg_value;
        end
        if (rd_en) begin
            r_opa <= (rd_addr_a == '0 || !r_reg_vld[rd_addr_a]) ? '0 : r_mem[rd_addr_a];
            r_opb <= (rd_addr_b == '0 || !r_reg_vld[rd_addr_b]) ? '0 : r_mem[rd_addr_b];
            r_s1  <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
        end else if (wr_en) begin
            r_reg_vld[i_in.reg_index] <= 1'b1;
        end
    end

    // ---------------- compute stage ----------------
    logic [31:0]     w;
    logic [31:0]     pc;
    logic            comp;
    logic [31:0]     imm_br;
    logic [31:0]     imm_jal;
    logic [31:0]     imm_cj;
    logic [31:0]     imm_cb;
    logic            take;
    logic [31:0]     offs;
    logic [31:0]     pc_sum;
    logic [31:0]     jalr_sum;
    logic            sel_jalr;
    logic            sel_jr;
    logic            ls;
    t_pred_out       n_out;

    always_comb begin
        w    = r_s1.instr_word;
        pc   = r_s1.pc;
        comp = (w[1:0] != CQ_NONE);

        imm_br  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        imm_jal = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        imm_cj  = {{21{w[12]}}, w[8], w[10], w[9], w[6], w[7], w[2], w[11],
                   w[5:3], 1'b0};
        imm_cb  = {{24{w[12]}}, w[6], w[5], w[2], w[11], w[10], w[4], w[3], 1'b0};

        jalr_sum = {{20{w[31]}}, w[31:20]} + r_opa;

        take     = 1'b0;
        sel_jalr = 1'b0;
        sel_jr   = 1'b0;
        offs     = comp ? 32'd2 : 32'd4;

        if (!comp) begin
            if ((w[6:0] & OPC_CTRL) == OPC_CTRL) begin
                case (w[4:2])
                    CTL_BRANCH: begin
                        case (w[14:12])
                            F3_BEQ:  take = (r_opa == r_opb);
                            F3_BNE:  take = (r_opa != r_opb);
                            F3_BLT:  take = ($signed(r_opa) <  $signed(r_opb));
                            F3_BGE:  take = ($signed(r_opa) >= $signed(r_opb));
                            F3_BLTU: take = (r_opa <  r_opb);
                            F3_BGEU: take = (r_opa >= r_opb);
                            default: take = 1'b0;
                        endcase
                        if (take) begin
                            offs = imm_br;
                        end
                    end
                    CTL_JAL:  offs = imm_jal;
                    CTL_JALR: sel_jalr = 1'b1;
                    default:  offs = 32'd4;
                endcase
            end
        end else if (w[1:0] == CQ1) begin
            case (w[15:13])
                CF3_JAL, CF3_J: offs = imm_cj;
                CF3_BEQZ:       if (r_opa == '0) offs = imm_cb;
                CF3_BNEZ:       if (r_opa != '0) offs = imm_cb;
                default:        offs = 32'd2;
            endcase
        end else if (w[1:0] == CQ2) begin
            // C.JR / C.JALR, taken only with a nonzero rs1 field
            if ((w[15:0] & CJR_MASK) == CJR_MATCH && w[11:7] != '0) begin
                sel_jr = 1'b1;
            end
        end

        pc_sum = pc + offs;

        ls = (w[6:0] == OPC_LOAD) || (w[6:0] == OPC_STORE)
          || ((w[1:0] == CQ0 || w[1:0] == CQ2)
              && (w[15:13] == CF3_LW || w[15:13] == CF3_SW));

        if (sel_jalr) begin
            n_out.next_pc = {jalr_sum[31:1], 1'b0};
        end else if (sel_jr) begin
            n_out.next_pc = {r_opa[31:1], 1'b0};
        end else begin
            n_out.next_pc = pc_sum;
        end
        n_out.is_load_store = ls;
        n_out.is_compressed = comp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (rd_en) begin
                r_s1_vld <= 1'b1;
            end else if (out_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

endmodule

`default_nettype wire
